// ===== sv/stc_pkg.sv =====
package stc_pkg;

  // Widths of the tank pressure and of the configuration port
  localparam int PRESSURE_BITS = 12;
  localparam int CFG_DATA_W    = 20;
  localparam int CFG_IDX_W     = 3;
  localparam int INTERVAL_W    = 27;

  typedef logic [PRESSURE_BITS-1:0] press_t;

  // Pressure values are limited to 12 bits of 0.01 bar
  localparam press_t P_MASK      = PRESSURE_BITS'(12'hFFF);
  localparam press_t EMPTY_LEVEL = PRESSURE_BITS'(10);

  localparam logic [INTERVAL_W-1:0] MS_PER_MIN = INTERVAL_W'(60000);

  // Operating modes, coded as seen on the result word
  typedef enum logic [2:0] {
    MODE_DISABLED,
    MODE_IDLE,
    MODE_SPRAY,
    MODE_STOP_SPRAY,
    MODE_RELEASE,
    MODE_REFILL,
    MODE_DRAIN,
    MODE_MIX
  } mode_e;

  // Action codes of the input word
  localparam logic [3:0] ACT_SLOW_TICK = 4'd0;
  localparam logic [3:0] ACT_FAST_TICK = 4'd1;
  localparam logic [3:0] ACT_SPRAY     = 4'd2;
  localparam logic [3:0] ACT_SPRAY_OFF = 4'd3;
  localparam logic [3:0] ACT_REFILL    = 4'd4;
  localparam logic [3:0] ACT_DRAIN     = 4'd5;
  localparam logic [3:0] ACT_MIX       = 4'd6;
  localparam logic [3:0] ACT_ENABLE    = 4'd7;
  localparam logic [3:0] ACT_DISABLE   = 4'd8;

  // Pump states as sampled by the caller
  localparam logic [2:0] PUMP_IDLE          = 3'd0;
  localparam logic [2:0] PUMP_DISABLED      = 3'd1;
  localparam logic [2:0] PUMP_BLOWOFF       = 3'd2;
  localparam logic [2:0] PUMP_BYPASS_CLOSE  = 3'd3;
  localparam logic [2:0] PUMP_BYPASS_OPEN   = 3'd4;
  localparam logic [2:0] PUMP_MIXING        = 3'd5;

  // Pump command bits
  localparam logic [5:0] CMD_STOP       = 6'b000001;
  localparam logic [5:0] CMD_REFILL     = 6'b000010;
  localparam logic [5:0] CMD_BLOWOFF    = 6'b000100;
  localparam logic [5:0] CMD_BYPASS_ON  = 6'b001000;
  localparam logic [5:0] CMD_BYPASS_OFF = 6'b010000;
  localparam logic [5:0] CMD_MIX        = 6'b100000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SPRAY_DUR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DAY_INT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NIGHT_INT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PRESS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PRESS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_DELAY = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_EN_AT_RESET = 3'd6;

  // Configuration as used by the step logic; intervals are held in ms
  typedef struct packed {
    logic [19:0]           spray_dur;
    logic [INTERVAL_W-1:0] day_ms;
    logic [INTERVAL_W-1:0] night_ms;
    press_t                min_p;
    press_t                max_p;
    logic [15:0]           close_delay;
    logic                  en_at_reset;
  } cfg_t;

  // One input word
  typedef struct packed {
    logic [3:0]  action;
    logic [31:0] time_ms;
    logic [2:0]  pump_state;
    press_t      pressure;
    logic        day_mode;
  } item_t;

endpackage

// ===== sv/stc_in_if.sv =====
interface stc_in_if;
  import stc_pkg::*;

  logic        valid;
  logic        ready;
  logic [3:0]  action;
  logic [31:0] time_ms;
  logic [2:0]  pump_state;
  press_t      pressure;
  logic        day_mode;

  modport source (
    output valid, action, time_ms, pump_state, pressure, day_mode,
    input  ready
  );

  modport sink (
    input  valid, action, time_ms, pump_state, pressure, day_mode,
    output ready
  );

endinterface

// ===== sv/stc_out_if.sv =====
interface stc_out_if;
  import stc_pkg::*;

  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic       spray_valve;
  logic [5:0] pump_commands;
  logic       spray_enabled;
  press_t     last_spray_pressure;

  modport source (
    output valid, mode, spray_valve, pump_commands, spray_enabled, last_spray_pressure,
    input  ready
  );

  modport sink (
    input  valid, mode, spray_valve, pump_commands, spray_enabled, last_spray_pressure,
    output ready
  );

endinterface

// ===== sv/stc_cfg_regs.sv =====
module stc_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [stc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [stc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output stc_pkg::cfg_t                  cfg_o
);
  import stc_pkg::*;

  cfg_t                  cfg_q;
  logic [INTERVAL_W-1:0] minutes_ms;

  // Turn a minute count into milliseconds on the way in
  assign minutes_ms = INTERVAL_W'(cfg_wdata_i[10:0]) * MS_PER_MIN;

  // Hold registers, load the addressed one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.spray_dur   <= 20'd5000;
      cfg_q.day_ms      <= INTERVAL_W'(15 * 60000);
      cfg_q.night_ms    <= INTERVAL_W'(30 * 60000);
      cfg_q.min_p       <= PRESSURE_BITS'(500);
      cfg_q.max_p       <= PRESSURE_BITS'(700);
      cfg_q.close_delay <= 16'd600;
      cfg_q.en_at_reset <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SPRAY_DUR:   cfg_q.spray_dur   <= cfg_wdata_i[19:0];
        CFG_DAY_INT:     cfg_q.day_ms      <= minutes_ms;
        CFG_NIGHT_INT:   cfg_q.night_ms    <= minutes_ms;
        CFG_MIN_PRESS:   cfg_q.min_p       <= PRESSURE_BITS'(cfg_wdata_i[11:0]);
        CFG_MAX_PRESS:   cfg_q.max_p       <= PRESSURE_BITS'(cfg_wdata_i[11:0]);
        CFG_CLOSE_DELAY: cfg_q.close_delay <= cfg_wdata_i[15:0];
        CFG_EN_AT_RESET: cfg_q.en_at_reset <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/stc_in_reg.sv =====
module stc_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  stc_in_if.sink         in_i,
  input  logic           take_i,
  output logic           valid_o,
  output stc_pkg::item_t item_o
);
  import stc_pkg::*;

  logic  valid_q;
  item_t item_q;
  logic  accept;

  // Free when empty or when the held word moves on this cycle
  assign in_i.ready = !valid_q || take_i;
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  // Capture the word; pressure is limited to its 12 significant bits
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.action     <= in_i.action;
      item_q.time_ms    <= in_i.time_ms;
      item_q.pump_state <= in_i.pump_state;
      item_q.pressure   <= in_i.pressure & P_MASK;
      item_q.day_mode   <= in_i.day_mode;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== sv/stc_step.sv =====
module stc_step (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  stc_pkg::cfg_t  cfg_i,
  input  logic           item_valid_i,
  input  stc_pkg::item_t item_i,
  output logic           item_take_o,
  stc_out_if.source      out_o
);
  import stc_pkg::*;

  typedef struct packed {
    mode_e       mode;
    logic        cyc_en;
    logic        valve;
    logic [31:0] istart;
    press_t      sep;
    logic [5:0]  cmds;
  } st_t;

  function automatic logic pump_free(input logic [2:0] p);
    return (p == PUMP_IDLE) || (p == PUMP_DISABLED);
  endfunction

  function automatic logic elapsed_ge(input logic [31:0] now, input logic [31:0] t0,
                                      input logic [31:0] lim);
    logic [31:0] dt;
    dt = now - t0;
    return dt >= lim;
  endfunction

  // Idle entry: only ever reached from another mode
  function automatic st_t f_idle_entry(input st_t s);
    st_t r;
    r        = s;
    r.cyc_en = 1'b1;
    r.valve  = 1'b0;
    r.cmds   = r.cmds | CMD_STOP;
    r.mode   = MODE_IDLE;
    return r;
  endfunction

  function automatic st_t f_disabled(input st_t s);
    st_t r;
    r = s;
    if (r.mode != MODE_DISABLED) begin
      r.cyc_en = 1'b0;
      r.valve  = 1'b0;
      r.cmds   = r.cmds | CMD_STOP;
      r.mode   = MODE_DISABLED;
    end
    return r;
  endfunction

  function automatic st_t f_release(input st_t s, input item_t it);
    st_t r;
    r = s;
    if (r.mode != MODE_RELEASE) begin
      r.cmds = r.cmds | CMD_BLOWOFF;
      r.mode = MODE_RELEASE;
    end else if (it.pump_state != PUMP_BLOWOFF && it.pump_state != PUMP_BYPASS_CLOSE) begin
      r = f_idle_entry(r);
    end
    return r;
  endfunction

  function automatic st_t f_stop_spray(input st_t s, input item_t it, input cfg_t c);
    st_t  r;
    logic entry;
    r     = s;
    entry = (r.mode != MODE_STOP_SPRAY);
    if (entry) begin
      r.valve  = 1'b0;
      r.istart = it.time_ms;
    end
    if (elapsed_ge(it.time_ms, r.istart, 32'(c.close_delay))) begin
      r.istart = it.time_ms;
      r = f_release(r, it);
    end else if (entry) begin
      r.mode = MODE_STOP_SPRAY;
    end
    return r;
  endfunction

  function automatic st_t f_spray(input st_t s, input item_t it, input cfg_t c);
    st_t  r;
    logic entry;
    r     = s;
    entry = (r.mode != MODE_SPRAY);
    if (entry) begin
      r.cyc_en = 1'b1;
      r.valve  = 1'b1;
      r.istart = it.time_ms;
    end
    if (elapsed_ge(it.time_ms, r.istart, 32'(c.spray_dur))) begin
      r.sep = it.pressure;
      r = f_stop_spray(r, it, c);
    end else if (entry) begin
      r.mode = MODE_SPRAY;
    end
    return r;
  endfunction

  function automatic st_t f_refill(input st_t s, input item_t it, input cfg_t c);
    st_t  r;
    logic entry;
    logic held;
    r     = s;
    held  = 1'b0;
    entry = (r.mode != MODE_REFILL);
    if (entry) begin
      r.cmds = r.cmds | CMD_REFILL;
    end
    if (it.pressure >= c.max_p) begin
      r    = f_release(r, it);
      held = 1'b1;
    end
    // Mode is never idle here, so the return to idle is always an entry
    if (!entry && pump_free(it.pump_state)) begin
      r    = f_idle_entry(r);
      held = 1'b1;
    end
    if (entry && !held) begin
      r.mode = MODE_REFILL;
    end
    return r;
  endfunction

  function automatic st_t f_idle(input st_t s, input item_t it, input cfg_t c);
    st_t                   r;
    logic [INTERVAL_W-1:0] iv_ms;
    logic                  due;
    logic                  low;
    r     = s;
    iv_ms = it.day_mode ? c.day_ms : c.night_ms;
    due   = pump_free(it.pump_state) && elapsed_ge(it.time_ms, r.istart, 32'(iv_ms));
    low   = (it.pump_state == PUMP_IDLE) && (it.pressure <= c.min_p);
    if (r.mode != MODE_IDLE) begin
      r = f_idle_entry(r);
    end else begin
      // Spray check first, then the refill check sees the mode it left
      if (due) begin
        r = f_spray(r, it, c);
      end
      if (low) begin
        r = f_refill(r, it, c);
      end
    end
    return r;
  endfunction

  function automatic st_t f_drain(input st_t s, input item_t it, input cfg_t c);
    st_t  r;
    logic entry;
    r     = s;
    entry = (r.mode != MODE_DRAIN);
    if (entry) begin
      r.cmds  = r.cmds | CMD_BYPASS_ON;
      r.valve = 1'b1;
    end
    if (it.pressure <= EMPTY_LEVEL || (!entry && pump_free(it.pump_state))) begin
      if (entry || it.pump_state == PUMP_BYPASS_OPEN) begin
        r.cmds = r.cmds | CMD_BYPASS_OFF;
      end
      r.valve = 1'b0;
      if (r.cyc_en) begin
        r = f_idle(r, it, c);
      end else begin
        r = f_disabled(r);
      end
    end else if (entry) begin
      r.mode = MODE_DRAIN;
    end
    return r;
  endfunction

  function automatic st_t f_mix(input st_t s, input item_t it);
    st_t r;
    r = s;
    if (r.mode != MODE_MIX) begin
      r.cmds = r.cmds | CMD_MIX;
      r.mode = MODE_MIX;
    end else if (it.pump_state != PUMP_MIXING) begin
      r = f_idle_entry(r);
    end
    return r;
  endfunction

  function automatic st_t f_go(input mode_e tgt, input st_t s, input item_t it,
                               input cfg_t c);
    st_t r;
    case (tgt)
      MODE_DISABLED:   r = f_disabled(s);
      MODE_IDLE:       r = f_idle(s, it, c);
      MODE_SPRAY:      r = f_spray(s, it, c);
      MODE_STOP_SPRAY: r = f_stop_spray(s, it, c);
      MODE_RELEASE:    r = f_release(s, it);
      MODE_REFILL:     r = f_refill(s, it, c);
      MODE_DRAIN:      r = f_drain(s, it, c);
      default:         r = f_mix(s, it);
    endcase
    return r;
  endfunction

  // Controller state
  mode_e       mode_q;
  logic        start_pending_q;
  logic        cyc_en_q;
  logic        valve_q;
  logic [31:0] istart_q;
  press_t      sep_q;

  // Result register
  logic       out_valid_q;
  logic [2:0] out_mode_q;
  logic       out_valve_q;
  logic [5:0] out_cmds_q;
  logic       out_en_q;
  press_t     out_sep_q;

  st_t  st_d;
  logic idle_or_off;

  // Move the held word on whenever the result register has room
  assign item_take_o = item_valid_i && (!out_valid_q || out_o.ready);

  // Run one word through start-up and its action
  always_comb begin
    st_d.mode   = mode_q;
    st_d.cyc_en = cyc_en_q;
    st_d.valve  = valve_q;
    st_d.istart = istart_q;
    st_d.sep    = sep_q;
    st_d.cmds   = '0;

    if (start_pending_q) begin
      st_d.cyc_en = cfg_i.en_at_reset;
      if (cfg_i.en_at_reset) begin
        st_d.mode = MODE_IDLE;
        st_d      = f_spray(st_d, item_i, cfg_i);
      end else begin
        st_d.mode = MODE_DISABLED;
      end
    end

    idle_or_off = (st_d.mode == MODE_IDLE) || (st_d.mode == MODE_DISABLED);

    case (item_i.action)
      ACT_SLOW_TICK: st_d = f_go(st_d.mode, st_d, item_i, cfg_i);
      ACT_FAST_TICK: begin
        if (st_d.mode == MODE_SPRAY || st_d.mode == MODE_STOP_SPRAY) begin
          st_d = f_go(st_d.mode, st_d, item_i, cfg_i);
        end
      end
      ACT_SPRAY: begin
        if (idle_or_off) begin
          st_d = f_spray(st_d, item_i, cfg_i);
        end
      end
      ACT_SPRAY_OFF: begin
        if (st_d.mode == MODE_SPRAY) begin
          st_d = f_stop_spray(st_d, item_i, cfg_i);
        end else begin
          st_d = f_idle(st_d, item_i, cfg_i);
        end
      end
      ACT_REFILL: begin
        if (idle_or_off) begin
          st_d = f_refill(st_d, item_i, cfg_i);
        end
      end
      ACT_DRAIN: begin
        if (idle_or_off) begin
          st_d = f_drain(st_d, item_i, cfg_i);
        end
      end
      ACT_MIX: begin
        if (idle_or_off) begin
          st_d = f_mix(st_d, item_i);
        end
      end
      ACT_ENABLE:  st_d = f_idle(st_d, item_i, cfg_i);
      ACT_DISABLE: st_d = f_disabled(st_d);
      default: ;
    endcase
  end

  // Hold state and result valid; advance both when a word is taken, else drop result valid once it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q          <= MODE_DISABLED;
      start_pending_q <= 1'b1;
      cyc_en_q        <= 1'b1;
      valve_q         <= 1'b0;
      istart_q        <= '0;
      sep_q           <= '0;
      out_valid_q     <= 1'b0;
    end else if (item_take_o) begin
      mode_q          <= st_d.mode;
      start_pending_q <= 1'b0;
      cyc_en_q        <= st_d.cyc_en;
      valve_q         <= st_d.valve;
      istart_q        <= st_d.istart;
      sep_q           <= st_d.sep;
      out_valid_q     <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q     <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (item_take_o) begin
      out_mode_q  <= st_d.mode;
      out_valve_q <= st_d.valve;
      out_cmds_q  <= st_d.cmds;
      out_en_q    <= st_d.cyc_en;
      out_sep_q   <= st_d.sep;
    end
  end

  assign out_o.valid               = out_valid_q;
  assign out_o.mode                = out_mode_q;
  assign out_o.spray_valve         = out_valve_q;
  assign out_o.pump_commands       = out_cmds_q;
  assign out_o.spray_enabled       = out_en_q;
  assign out_o.last_spray_pressure = out_sep_q;

endmodule

// ===== sv/spray_tank_cycle_controller.sv =====
// Channel   Dir  Handshake      Payload
// in_i      in   valid/ready    action, time_ms, pump_state, pressure, day_mode
// out_o     out  valid/ready    mode, spray_valve, pump_commands, spray_enabled,
//                               last_spray_pressure
// cfg       in   cfg_we_i       cfg_idx_i, cfg_wdata_i (write only)
//
// One word per clock sustained while the output is not stalled; a result is
// held in the result register once its word has left the input register.
// The rate is set by the mode and timer loop, which closes through the step
// logic between the input register and the result register.
// Reset clears the mode and timers; the first word runs the start-up sequence.
// An input register and a result register each hold one word, so input ready
// falls only when both are full and the result is not being taken.
module spray_tank_cycle_controller (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  stc_in_if.sink                         in_i,
  stc_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [stc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [stc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import stc_pkg::*;

  cfg_t  cfg;
  item_t item;
  logic  item_valid;
  logic  item_take;

  stc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  stc_in_reg u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (item_take),
    .valid_o (item_valid),
    .item_o  (item)
  );

  stc_step u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .out_o        (out_o)
  );

endmodule

// ===== sv/stc_checker.sv =====
module stc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [2:0]                   mode_i,
  input logic                         spray_valve_i,
  input logic [5:0]                   pump_commands_i,
  input logic                         spray_enabled_i,
  input logic [stc_pkg::PRESSURE_BITS-1:0] last_spray_pressure_i
);
  import stc_pkg::*;

  // A stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(mode_i) && $stable(spray_valve_i) &&
      $stable(pump_commands_i) && $stable(spray_enabled_i) &&
      $stable(last_spray_pressure_i))
    else $error("result word changed while stalled");

  // A result appearing on an empty output follows an earlier accepted input word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result without a matching input word");

  // Disabled means valve closed and cycle off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && mode_i == MODE_DISABLED |-> !spray_valve_i && !spray_enabled_i)
    else $error("disabled mode with valve open or cycle enabled");

  // Spraying means valve open and cycle on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && mode_i == MODE_SPRAY |-> spray_valve_i && spray_enabled_i)
    else $error("spray mode with valve closed or cycle disabled");

endmodule

bind spray_tank_cycle_controller stc_checker u_stc_checker (
  .clk_i                 (clk_i),
  .rst_ni                (rst_ni),
  .in_valid_i            (in_i.valid),
  .in_ready_i            (in_i.ready),
  .out_valid_i           (out_o.valid),
  .out_ready_i           (out_o.ready),
  .mode_i                (out_o.mode),
  .spray_valve_i         (out_o.spray_valve),
  .pump_commands_i       (out_o.pump_commands),
  .spray_enabled_i       (out_o.spray_enabled),
  .last_spray_pressure_i (out_o.last_spray_pressure)
);
